// ----- hw/rtl/sphere_sphere_contact_macros.svh -----
// Assertion macros shared by the sphere contact RTL.
`ifndef SPHERE_SPHERE_CONTACT_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define SSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold, checked out of reset.
`define SSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssc_pkg.sv -----
// Shared constants and helpers for the sphere contact pipeline.
package ssc_pkg;

  // Integer bits of the Q2.x normal format.
  localparam int NORMAL_INT_BITS = 2;
  localparam int BYTE_W = 8;

  // Round a bit count up to whole bytes.
  function automatic int byte_pad(input int bits);
    return ((bits + BYTE_W - 1) / BYTE_W) * BYTE_W;
  endfunction

endpackage

// ----- hw/rtl/sphere_sphere_contact.sv -----
// Sphere versus sphere contact test: top level of the streaming pipeline.
//
// Each input beat on s_tdata carries two spheres (centers A and B, signed
// Q12.12, and unsigned Q11.12 radii). Each accepted beat yields exactly one
// output beat: m_tuser is the hit flag and m_tdata holds the unit normal
// from A toward B in Q2.14 and the penetration depth in Q12.12. Without
// contact every output field is zero; with coincident centers the normal
// is zero and the depth is the radius sum.
// The pipeline accepts one beat per clock while s_tready is high. From
// acceptance to the result beat an item passes three front stages
// (difference, squares, sum), one stage per root bit of the square root, a
// compare stage, a dividend setup stage, one stage per quotient bit of the
// normal divider, and the output register.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and s_tready stays high while the
// pipeline has any free stage, even with a result waiting on m_tready.
// When m_tready is held low the output beat holds and the stages fill up;
// s_tready falls only once every stage holds an item. Nothing is dropped.
// Synchronous reset clears all valid bits; payload registers are not reset.
`include "sphere_sphere_contact_macros.svh"

module sphere_sphere_contact #(
  parameter int COORD_BITS = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius (lowest bits first)
  input  logic [ssc_pkg::byte_pad(8*COORD_BITS-2)-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // normal_x, normal_y, normal_z, depth (lowest bits first)
  output logic [ssc_pkg::byte_pad(3*(NORMAL_FRAC_BITS+ssc_pkg::NORMAL_INT_BITS)
                                  + COORD_BITS)-1:0] m_tdata,
  // hit
  output logic m_tuser
);

  localparam int C = COORD_BITS;
  localparam int D = C + 1;
  localparam int NF = NORMAL_FRAC_BITS;
  localparam int NW = NF + ssc_pkg::NORMAL_INT_BITS;
  localparam int OUT_W = 3 * NW + C;
  localparam int M_W = ssc_pkg::byte_pad(OUT_W);
  localparam int SQ_SIDE_W = 3 + 3 * D + C;
  localparam int DIV_SIDE_W = 5 + C;

  // Input unpacking.
  logic [2:0][C-1:0] a_pos, b_pos;
  logic [C-2:0] a_radius, b_radius;

  assign a_pos[0] = s_tdata[0 +: C];
  assign a_pos[1] = s_tdata[C +: C];
  assign a_pos[2] = s_tdata[2*C +: C];
  assign a_radius = s_tdata[3*C +: C-1];
  assign b_pos[0] = s_tdata[4*C-1 +: C];
  assign b_pos[1] = s_tdata[5*C-1 +: C];
  assign b_pos[2] = s_tdata[6*C-1 +: C];
  assign b_radius = s_tdata[7*C-1 +: C-1];

  // Front end.
  logic fr_valid, fr_ready;
  logic [2:0] fr_neg;
  logic [2:0][D-1:0] fr_mag;
  logic [C-1:0] fr_rsum;
  logic [2*D-1:0] fr_sumsq;

  ssc_front #(.C(C)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .a_pos     (a_pos),
    .b_pos     (b_pos),
    .a_radius  (a_radius),
    .b_radius  (b_radius),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_neg   (fr_neg),
    .out_mag   (fr_mag),
    .out_rsum  (fr_rsum),
    .out_sumsq (fr_sumsq)
  );

  // Square root; the signs, magnitudes and radius sum ride alongside.
  logic sq_valid, sq_ready;
  logic [D-1:0] sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic [2:0] sq_neg;
  logic [2:0][D-1:0] sq_mag;
  logic [C-1:0] sq_rsum;

  ssc_sqrt #(.D(D), .SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .radicand  (fr_sumsq),
    .in_side   ({fr_neg, fr_mag, fr_rsum}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign {sq_neg, sq_mag, sq_rsum} = sq_side;

  // Contact decision and depth.
  logic cm_valid, cm_en, dv_ready;
  logic cm_hit, cm_zero;
  logic [2:0] cm_neg;
  logic [2:0][D-1:0] cm_mag;
  logic [D-1:0] cm_dist;
  logic [C-1:0] cm_depth;

  assign cm_en = ~cm_valid | dv_ready;
  assign sq_ready = cm_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cm_valid <= 1'b0;
    end else if (cm_en) begin
      cm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cm_en) begin
      cm_hit <= D'(sq_rsum) > sq_root;
      cm_zero <= sq_root == '0;
      cm_depth <= sq_rsum - C'(sq_root);
      cm_neg <= sq_neg;
      cm_mag <= sq_mag;
      cm_dist <= sq_root;
    end
  end

  // Normal divider.
  logic dq_valid, dq_ready;
  logic [2:0][NF:0] dq_quo;
  logic [DIV_SIDE_W-1:0] dq_side;
  logic dq_hit, dq_zero;
  logic [2:0] dq_neg;
  logic [C-1:0] dq_depth;

  ssc_div #(.D(D), .NF(NF), .SIDE_W(DIV_SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cm_valid),
    .in_ready  (dv_ready),
    .divisor   (cm_dist),
    .mag       (cm_mag),
    .in_side   ({cm_hit, cm_zero, cm_neg, cm_depth}),
    .out_valid (dq_valid),
    .out_ready (dq_ready),
    .quo       (dq_quo),
    .out_side  (dq_side)
  );

  assign {dq_hit, dq_zero, dq_neg, dq_depth} = dq_side;

  // Output register: apply signs and clear fields when there is no contact.
  logic out_valid, out_en, out_hit;
  logic [2:0][NW-1:0] out_normal;
  logic [2:0][NW-1:0] normal_c;
  logic [C-1:0] out_depth;

  assign out_en = ~out_valid | m_tready;
  assign dq_ready = out_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dq_hit && !dq_zero) begin
        normal_c[i] = dq_neg[i] ? (~NW'(dq_quo[i]) + NW'(1)) : NW'(dq_quo[i]);
      end else begin
        normal_c[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_hit <= dq_hit;
      out_normal <= normal_c;
      out_depth <= dq_hit ? dq_depth : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser = out_hit;
  assign m_tdata = M_W'({out_depth, out_normal[2], out_normal[1], out_normal[0]});

  `SSC_ASSERT_NEVER(a_miss_clears, clk, rst, m_tvalid && !m_tuser && (m_tdata != '0), "fields set without contact")
  `SSC_ASSERT_IMPL(a_hit_depth, clk, rst, m_tvalid && m_tuser, m_tdata[3*NW +: C] != '0, "contact with zero depth")
  `SSC_ASSERT_IMPL(a_full_stall, clk, rst, !s_tready, m_tvalid && !m_tready, "input blocked while output free")

endmodule

// ----- hw/rtl/ssc_front.sv -----
// Front end: center differences, magnitudes, squares and their sum.
module ssc_front #(
  parameter int C = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0][C-1:0]      a_pos,
  input  logic [2:0][C-1:0]      b_pos,
  input  logic [C-2:0]           a_radius,
  input  logic [C-2:0]           b_radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_neg,
  output logic [2:0][C:0]        out_mag,
  output logic [C-1:0]           out_rsum,
  output logic [2*(C+1)-1:0]     out_sumsq
);

  localparam int D = C + 1;

  logic v1, v2, v3, en1, en2, en3;
  logic [2:0] neg1, neg2, neg3;
  logic [2:0][D-1:0] mag1, mag2, mag3;
  logic [C-1:0] rsum1, rsum2, rsum3;
  logic [2:0][2*D-2:0] sq2;
  logic [2*D-1:0] sum3;
  logic [2:0][D-1:0] diff;
  logic [2:0][D-1:0] mag_c;
  logic [2:0][2*D-1:0] prod;

  assign en3 = ~v3 | out_ready;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;
  assign in_ready = en1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {b_pos[i][C-1], b_pos[i]} - {a_pos[i][C-1], a_pos[i]};
      mag_c[i] = diff[i][D-1] ? (~diff[i] + D'(1)) : diff[i];
      prod[i] = mag1[i] * mag1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= diff[i][D-1];
        mag1[i] <= mag_c[i];
      end
      rsum1 <= C'(a_radius) + C'(b_radius);
    end
    if (en2) begin
      neg2 <= neg1;
      mag2 <= mag1;
      rsum2 <= rsum1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= prod[i][2*D-2:0];
      end
    end
    if (en3) begin
      neg3 <= neg2;
      mag3 <= mag2;
      rsum3 <= rsum2;
      sum3 <= (2*D)'(sq2[0]) + (2*D)'(sq2[1]) + (2*D)'(sq2[2]);
    end
  end

  assign out_valid = v3;
  assign out_neg = neg3;
  assign out_mag = mag3;
  assign out_rsum = rsum3;
  assign out_sumsq = sum3;

endmodule

// ----- hw/rtl/ssc_sqrt.sv -----
// Pipelined integer square root, one root bit resolved per stage.
module ssc_sqrt #(
  parameter int D = 25,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2*D-1:0]    radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [D-1:0]      root,
  output logic [SIDE_W-1:0] out_side
);

  logic              v    [D];
  logic              en   [D+1];
  logic [2*D-1:0]    rem  [D];
  logic [D-1:0]      rt   [D];
  logic [SIDE_W-1:0] side [D];

  assign en[D] = out_ready;

  for (genvar k = 0; k < D; k++) begin : g_stage
    localparam int BIT = D - 1 - k;
    logic              pv;
    logic [2*D-1:0]    prem;
    logic [D-1:0]      prt;
    logic [SIDE_W-1:0] pside;
    logic [2*D-1:0]    trial;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign prem = radicand;
      assign prt = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv = v[k-1];
      assign prem = rem[k-1];
      assign prt = rt[k-1];
      assign pside = side[k-1];
    end

    // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
    assign trial = ((2*D)'(prt) << (BIT + 1)) + ((2*D)'(1) << (2 * BIT));
    assign en[k] = ~v[k] | en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side[k] <= pside;
        if (prem >= trial) begin
          rem[k] <= prem - trial;
          rt[k] <= prt | (D'(1) << BIT);
        end else begin
          rem[k] <= prem;
          rt[k] <= prt;
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = v[D-1];
  assign root = rt[D-1];
  assign out_side = side[D-1];

endmodule

// ----- hw/rtl/ssc_div.sv -----
// Pipelined rounded division of three magnitudes by the distance.
module ssc_div #(
  parameter int D = 25,
  parameter int NF = 14,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [D-1:0]         divisor,
  input  logic [2:0][D-1:0]    mag,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0][NF:0]     quo,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int W = D + NF + 1;
  localparam int L = NF + 2;

  logic                 v    [L];
  logic                 en   [L+1];
  logic [2:0][W-1:0]    rem  [L];
  logic [2:0][NF:0]     q    [L];
  logic [D-1:0]         dv   [L];
  logic [SIDE_W-1:0]    side [L];

  assign en[L] = out_ready;
  assign en[0] = ~v[0] | en[1];

  // Dividend setup: magnitude scaled by 2^NF plus half the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= (W'(mag[i]) << NF) + W'(divisor >> 1);
      end
      q[0] <= '0;
      dv[0] <= divisor;
      side[0] <= in_side;
    end
  end

  for (genvar k = 1; k < L; k++) begin : g_step
    localparam int BIT = NF + 1 - k;
    logic [W-1:0] dsh;

    assign dsh = W'(dv[k-1]) << BIT;
    assign en[k] = ~v[k] | en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        dv[k] <= dv[k-1];
        side[k] <= side[k-1];
        for (int i = 0; i < 3; i++) begin
          if (rem[k-1][i] >= dsh) begin
            rem[k][i] <= rem[k-1][i] - dsh;
            q[k][i] <= q[k-1][i] | ((NF+1)'(1) << BIT);
          end else begin
            rem[k][i] <= rem[k-1][i];
            q[k][i] <= q[k-1][i];
          end
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = v[L-1];
  assign quo = q[L-1];
  assign out_side = side[L-1];

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sphere versus sphere contact pipeline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int NFB = 14;
  localparam int NW = NFB + 2;
  localparam int S_W = ssc_pkg::byte_pad(8 * CB - 2);
  localparam int M_W = ssc_pkg::byte_pad(3 * NW + CB);
  localparam int LATENCY = CB + NFB + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1800;

  typedef struct {
    logic signed [CB-1:0] ax, ay, az;
    logic [CB-2:0] ar;
    logic signed [CB-1:0] bx, by, bz;
    logic [CB-2:0] br;
  } pair_t;

  typedef struct {
    logic hit;
    logic [NW-1:0] nx, ny, nz;
    logic [CB-1:0] depth;
  } contact_t;

  // Holds the contacts that the pipeline still owes, oldest first.
  class contact_scoreboard;
    contact_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Rounded-to-nearest component of d / span in Q2.14, ties away from zero.
    static function logic [NW-1:0] unit_component(longint d, longint unsigned span);
      longint unsigned m;
      longint unsigned q;
      m = (d < 0) ? longint'(-d) : d;
      if (span == 0) return '0;
      q = ((m << NFB) + (span >> 1)) / span;
      if (d < 0) q = -q;
      return q[NW-1:0];
    endfunction

    function void note_pair(pair_t p);
      longint dx, dy, dz;
      logic [127:0] sq;
      logic [127:0] cand;
      longint unsigned root, rsum;
      contact_t c;
      dx = longint'(p.bx) - longint'(p.ax);
      dy = longint'(p.by) - longint'(p.ay);
      dz = longint'(p.bz) - longint'(p.az);
      sq = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
      root = 0;
      for (int b = 40; b >= 0; b--) begin
        cand = 128'(root | (64'd1 << b));
        if (cand * cand <= sq) root = cand[63:0];
      end
      rsum = longint'(p.ar) + longint'(p.br);
      c = '{default: '0};
      if (rsum > root) begin
        c.hit = 1'b1;
        c.nx = unit_component(dx, root);
        c.ny = unit_component(dy, root);
        c.nz = unit_component(dz, root);
        c.depth = CB'(rsum - root);
      end
      pending.push_back(c);
    endfunction

    function void check_contact(contact_t got);
      contact_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0d", $realtime, got.hit);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.hit !== w.hit) begin
        $display("%0t: hit expected %0d actual %0d", $realtime, w.hit, got.hit);
        errors++;
      end
      if (got.nx !== w.nx) begin
        $display("%0t: normal_x expected %0h actual %0h", $realtime, w.nx, got.nx);
        errors++;
      end
      if (got.ny !== w.ny) begin
        $display("%0t: normal_y expected %0h actual %0h", $realtime, w.ny, got.ny);
        errors++;
      end
      if (got.nz !== w.nz) begin
        $display("%0t: normal_z expected %0h actual %0h", $realtime, w.nz, got.nz);
        errors++;
      end
      if (got.depth !== w.depth) begin
        $display("%0t: depth expected %0h actual %0h", $realtime, w.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic m_tuser;

  contact_scoreboard sb = new();
  pair_t directed_pairs[$];
  bit stim_done = 1'b0;
  bit quiet_phase = 1'b0;   // no idling on either side near the end
  bit hold_off = 1'b0;      // receiver holds off for a long stretch
  int idle_cycles = 0;

  always #5 clk = ~clk;

  sphere_sphere_contact #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NFB)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  function automatic logic [S_W-1:0] pack_pair(pair_t p);
    return S_W'({p.br, p.bz, p.by, p.bx, p.ar, p.az, p.ay, p.ax});
  endfunction

  function automatic logic [CB-1:0] rand_coord();
    return CB'($urandom);
  endfunction

  // Mostly pairs that sit near each other, so contacts are common, plus
  // full-range noise and occasional large radii.
  function automatic pair_t rand_pair();
    pair_t p;
    int spread;
    p.ax = rand_coord();
    p.ay = rand_coord();
    p.az = rand_coord();
    case ($urandom_range(0, 9))
      0, 1: begin
        p.bx = rand_coord();
        p.by = rand_coord();
        p.bz = rand_coord();
        p.ar = (CB-1)'($urandom);
        p.br = (CB-1)'($urandom);
      end
      default: begin
        spread = 1 << $urandom_range(0, 20);
        p.bx = p.ax + CB'($urandom_range(0, 2 * spread) - spread);
        p.by = p.ay + CB'($urandom_range(0, 2 * spread) - spread);
        p.bz = p.az + CB'($urandom_range(0, 2 * spread) - spread);
        p.ar = (CB-1)'($urandom_range(0, 2 * spread));
        p.br = (CB-1)'($urandom_range(0, 2 * spread));
      end
    endcase
    return p;
  endfunction

  // Offers one pair and waits until the pipeline takes it.
  task automatic send_pair(pair_t p);
    s_tvalid <= 1'b1;
    s_tdata <= pack_pair(p);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pair(p);
  endtask

  task automatic sender_gap();
    int n;
    if (quiet_phase || $urandom_range(0, 5) != 0) return;
    n = $urandom_range(1, 8);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic pair_t make_pair(int ax, int ay, int az, int ar,
                                      int bx, int by, int bz, int br);
    pair_t p;
    p.ax = CB'(ax); p.ay = CB'(ay); p.az = CB'(az); p.ar = (CB-1)'(ar);
    p.bx = CB'(bx); p.by = CB'(by); p.bz = CB'(bz); p.br = (CB-1)'(br);
    return p;
  endfunction

  initial begin
    int maxc, minc, maxr;
    maxc = (1 << (CB - 1)) - 1;
    minc = -(1 << (CB - 1));
    maxr = (1 << (CB - 1)) - 1;
    // Coincident centers, with and without radius.
    directed_pairs.push_back(make_pair(0, 0, 0, 4096, 0, 0, 0, 4096));
    directed_pairs.push_back(make_pair(100, -5, 7, 0, 100, -5, 7, 0));
    directed_pairs.push_back(make_pair(minc, minc, minc, maxr, minc, minc, minc, maxr));
    // Touching spheres (zero penetration is no contact) and spheres one unit closer.
    directed_pairs.push_back(make_pair(0, 0, 0, 4096, 8192, 0, 0, 4096));
    directed_pairs.push_back(make_pair(0, 0, 0, 4096, 8191, 0, 0, 4096));
    directed_pairs.push_back(make_pair(0, 0, 0, 4096, 0, -8191, 0, 4096));
    directed_pairs.push_back(make_pair(0, 0, 0, 4096, 0, 0, 8191, 4096));
    // Opposite corners of the coordinate range.
    directed_pairs.push_back(make_pair(minc, minc, minc, maxr, maxc, maxc, maxc, maxr));
    directed_pairs.push_back(make_pair(maxc, maxc, maxc, maxr, minc, minc, minc, maxr));
    directed_pairs.push_back(make_pair(minc, 0, 0, maxr, maxc, 0, 0, maxr));
    directed_pairs.push_back(make_pair(maxc, 0, 0, maxr, minc, 0, 0, 0));
    // Diagonal normals and small offsets.
    directed_pairs.push_back(make_pair(0, 0, 0, 10000, 3, 4, 0, 10000));
    directed_pairs.push_back(make_pair(0, 0, 0, 100, -1, -1, -1, 100));
    directed_pairs.push_back(make_pair(0, 0, 0, 0, 1, 0, 0, 2));
    directed_pairs.push_back(make_pair(-1, -1, -1, 1, 0, 0, 0, 0));
  end

  // Stimulus: directed pairs, then random ones with a long receiver hold-off.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_pairs[i]) send_pair(directed_pairs[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off <= 1'b1;
      if (i == N_RANDOM - 200) quiet_phase <= 1'b1;
      send_pair(rand_pair());
      sender_gap();
    end
    s_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: random stall bursts plus one long hold-off that fills the pipe.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off <= 1'b0;
        m_tready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Checks each result beat as it is accepted.
  always @(posedge clk) begin
    contact_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.nx = m_tdata[NW-1:0];
      got.ny = m_tdata[2*NW-1:NW];
      got.nz = m_tdata[3*NW-1:2*NW];
      got.depth = m_tdata[3*NW+CB-1:3*NW];
      got.hit = m_tuser;
      sb.check_contact(got);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
